>>> rtl/core/hec_pkg.sv
package hec_pkg;

  localparam int WORD_W     = 64;
  localparam int DATA_W     = 57;
  localparam int DLEN_W     = 6;
  localparam int RLEN_W     = 7;
  localparam int POS_W      = 6;
  localparam int DATA_LIMIT = 57;

  typedef enum logic {
    REQ_ENCODE = 1'b0,
    REQ_CHECK  = 1'b1
  } req_type_t;

  typedef struct packed {
    req_type_t           req_type;
    logic [DATA_W-1:0]   data_bits;
    logic [DLEN_W-1:0]   data_length;
    logic [WORD_W-1:0]   received_word;
    logic [RLEN_W-1:0]   received_length;
  } hec_req_t;

  typedef struct packed {
    logic [WORD_W-1:0]   codeword;
    logic [RLEN_W-1:0]   code_length;
    logic                error_found;
    logic [POS_W-1:0]    error_position;
  } hec_res_t;

  // Smallest r with 2^r >= k + r + 1, for k below 64.
  function automatic logic [2:0] parity_count(logic [DLEN_W-1:0] k);
    int cnt;
    cnt = 1;
    for (int i = 1; i <= 6; i++) begin
      if ((1 << i) < int'(k) + i + 1) begin
        cnt++;
      end
    end
    return 3'(cnt);
  endfunction

  // Largest data length whose codeword still fits within code_max bits.
  function automatic int data_max(int code_max);
    int k;
    k = DATA_LIMIT;
    for (int i = 0; i < DATA_LIMIT; i++) begin
      if (k > 1 && k + int'(parity_count(DLEN_W'(k))) > code_max) begin
        k--;
      end
    end
    return k;
  endfunction

  // Positions covered by the parity bit at position 2^j, excluding that position.
  function automatic logic [WORD_W-1:0] cover_mask(int j);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int pos = 1; pos <= WORD_W; pos++) begin
      if (((pos >> j) & 1) == 1 && pos != (1 << j)) begin
        m[pos-1] = 1'b1;
      end
    end
    return m;
  endfunction

endpackage

>>> rtl/core/hec_if.sv
interface hec_req_if;
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [hec_pkg::DATA_W-1:0] data_bits;
  logic [hec_pkg::DLEN_W-1:0] data_length;
  logic [hec_pkg::WORD_W-1:0] received_word;
  logic [hec_pkg::RLEN_W-1:0] received_length;

  modport source (output valid, req_type, data_bits, data_length, received_word,
                  received_length, input ready);
  modport sink (input valid, req_type, data_bits, data_length, received_word,
                received_length, output ready);
endinterface

interface hec_res_if;
  logic                      valid;
  logic                      ready;
  logic [hec_pkg::WORD_W-1:0] codeword;
  logic [hec_pkg::RLEN_W-1:0] code_length;
  logic                      error_found;
  logic [hec_pkg::POS_W-1:0]  error_position;

  modport source (output valid, codeword, code_length, error_found, error_position,
                  input ready);
  modport sink (input valid, codeword, code_length, error_found, error_position,
                output ready);
endinterface

>>> rtl/core/hec_code.sv
module hec_code #(
  parameter int CODE_MAX = 64
) (
  input  hec_pkg::hec_req_t req,
  output hec_pkg::hec_res_t res
);
  import hec_pkg::*;

  localparam int KMAX = data_max(CODE_MAX);

  logic [DLEN_W-1:0] k;
  logic [2:0]        r;
  logic [RLEN_W-1:0] n;
  logic [DATA_W-1:0] data_masked;
  logic [WORD_W-1:0] placed;
  logic [WORD_W-1:0] codeword;
  logic [RLEN_W-1:0] len;
  logic [WORD_W-1:0] word_masked;
  logic [POS_W-1:0]  syn;

  always_comb begin
    if (req.data_length == '0) begin
      k = DLEN_W'(1);
    end else if (req.data_length > DLEN_W'(DATA_LIMIT)) begin
      k = DLEN_W'(DATA_LIMIT);
    end else begin
      k = req.data_length;
    end
    if (k > DLEN_W'(KMAX)) begin
      k = DLEN_W'(KMAX);
    end
  end

  assign r = parity_count(k);
  assign n = RLEN_W'(k) + RLEN_W'(r);

  always_comb begin
    int idx;
    idx = 0;
    for (int i = 0; i < DATA_W; i++) begin
      data_masked[i] = req.data_bits[i] & (i < int'(k));
    end
    placed = '0;
    for (int pos = 1; pos <= WORD_W; pos++) begin
      if ((pos & (pos - 1)) != 0) begin
        if (idx < DATA_W) begin
          placed[pos-1] = data_masked[idx];
        end
        idx++;
      end
    end
  end

  always_comb begin
    codeword = placed;
    for (int j = 0; j < POS_W; j++) begin
      if (RLEN_W'(1 << j) <= n) begin
        codeword[(1 << j) - 1] = ^(placed & cover_mask(j));
      end
    end
  end

  assign len = (req.received_length > RLEN_W'(CODE_MAX)) ? RLEN_W'(CODE_MAX)
                                                         : req.received_length;

  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      word_masked[i] = req.received_word[i] & (i < int'(len));
    end
    for (int j = 0; j < POS_W; j++) begin
      syn[j] = (RLEN_W'(1 << j) < len) & ^(word_masked & cover_mask(j));
      syn[j] = syn[j] & 1'b1;
      if (RLEN_W'(1 << j) < len) begin
        syn[j] = ^(word_masked & cover_mask(j)) ^ word_masked[(1 << j) - 1];
      end else begin
        syn[j] = 1'b0;
      end
    end
  end

  always_comb begin
    res = '0;
    unique case (req.req_type)
      REQ_ENCODE: begin
        res.codeword    = codeword;
        res.code_length = n;
      end
      REQ_CHECK: begin
        res.error_found    = |syn;
        res.error_position = (syn != '0) ? syn - POS_W'(1) : '0;
      end
      default: res = '0;
    endcase
  end

endmodule

>>> rtl/core/hamming_encode_and_check_unit.sv
// Variable-length even-parity Hamming encoder and checker. An encode request
// (req_type 0) returns the codeword with parity at the power-of-two positions
// and its length; a check request (req_type 1) returns whether the syndrome is
// nonzero and the zero-based error position. Bit 0 of every word is position 1.
// The block accepts one request every clock cycle while the result is not
// stalled; a request passes from the request register through the XOR trees
// into the result register. The result register lets a new request enter the
// empty request register while a finished result waits to be taken.
module hamming_encode_and_check_unit #(
  parameter int CODE_MAX = 64
) (
  input logic     clk,
  input logic     rst,
  hec_req_if.sink req,
  hec_res_if.source res
);
  import hec_pkg::*;

  hec_req_t req_q;
  logic     req_valid;
  hec_res_t res_d;
  hec_res_t res_q;
  logic     res_valid;
  logic     res_adv;

  assign res_adv   = !res_valid || res.ready;
  assign req.ready = !req_valid || res_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (req.ready) begin
        req_valid <= req.valid;
      end
      if (res_adv) begin
        res_valid <= req_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      req_q.req_type        <= req_type_t'(req.req_type);
      req_q.data_bits       <= req.data_bits;
      req_q.data_length     <= req.data_length;
      req_q.received_word   <= req.received_word;
      req_q.received_length <= req.received_length;
    end
    if (res_adv && req_valid) begin
      res_q <= res_d;
    end
  end

  hec_code #(
    .CODE_MAX(CODE_MAX)
  ) u_code (
    .req(req_q),
    .res(res_d)
  );

  assign res.valid          = res_valid;
  assign res.codeword       = res_q.codeword;
  assign res.code_length    = res_q.code_length;
  assign res.error_found    = res_q.error_found;
  assign res.error_position = res_q.error_position;

  a_accept_loads : assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> req_valid)
    else $error("accepted request not held in the request register");

  a_no_error_pos : assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.error_found) |-> (res.error_position == '0))
    else $error("error position set without an error");

  a_kind_exclusive : assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !(res.error_found && res.code_length != '0))
    else $error("result carries both encode and check fields");

  a_length_range : assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.code_length != '0) |->
      (res.code_length >= RLEN_W'(3) && res.code_length <= RLEN_W'(CODE_MAX)))
    else $error("code length out of range");

endmodule
